// ----- hw/rtl/scf_pkg.sv -----
`default_nettype none
package scf_pkg;

	localparam int FRAC_BITS = 8;
	localparam int COORD_BITS = 25;
	localparam int REG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int ACT_W = 3;
	localparam int DT_W = 16;
	localparam int RAD_W = 24;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int CMP_W = COORD_BITS + 3;
	localparam int MUL_A_W = COORD_BITS + REG_W;
	localparam int MUL_B_W = COORD_BITS;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);
	localparam int SUM_W = MUL_P_W - DT_W + 2;
	localparam int ROOT_W = DIFF_W;
	localparam int RD_W = 2 * DIFF_W;
	localparam int RD_CNT_W = $clog2(RD_W);
	localparam int DIV_R_W = ROOT_W + 1;
	localparam int STEP_W = 2 * REG_W - (16 - FRAC_BITS);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam logic [REG_W-1:0] VW_RST = REG_W'(1280);
	localparam logic [REG_W-1:0] VH_RST = REG_W'(720);
	localparam logic [REG_W-1:0] FS_RST = REG_W'(2000);
	localparam logic [REG_W-1:0] MS_RST = REG_W'(500);
	localparam coord_t TGT_X_RST = COORD_BITS'({VW_RST, {(FRAC_BITS-1){1'b0}}});
	localparam coord_t TGT_Y_RST = COORD_BITS'({VH_RST, {(FRAC_BITS-1){1'b0}}});
	localparam logic [ROOT_W-1:0] ONE_PX = ROOT_W'(1) << FRAC_BITS;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO =
		{{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

	typedef enum logic [ACT_W-1:0] {
		A_TARGET = 3'd0,
		A_FOLLOW = 3'd1,
		A_SNAP = 3'd2,
		A_MANUAL = 3'd3,
		A_SETPOS = 3'd4,
		A_VIS = 3'd5,
		A_W2S = 3'd6,
		A_S2W = 3'd7
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		R_VW = 3'd0,
		R_VH = 3'd1,
		R_MW = 3'd2,
		R_MH = 3'd3,
		R_FS = 3'd4,
		R_MS = 3'd5,
		R_MODE = 3'd6
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_DES,
		S_DIFF,
		S_SQ,
		S_SQW,
		S_ROOT,
		S_ROOTW,
		S_STEP,
		S_STEPW,
		S_DEC,
		S_PS,
		S_PSW,
		S_PD,
		S_PDW,
		S_M1,
		S_M1W,
		S_M2,
		S_M2W,
		S_CLAMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic root;
	} rd_ctl_t;

	function automatic coord_t sat_c(input logic signed [SUM_W-1:0] v);
		coord_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic coord_t clamp_axis(input coord_t p, input logic [REG_W-1:0] map,
			input logic [REG_W-1:0] vp);
		logic signed [REG_W+1:0] span;
		coord_t spe;
		coord_t lim;
		coord_t r;
		span = $signed({2'b00, map}) - $signed({2'b00, vp});
		spe = $signed(COORD_BITS'(span));
		lim = spe <<< FRAC_BITS;
		if (map <= vp) begin
			r = spe <<< (FRAC_BITS - 1);
		end else if (p > lim) begin
			r = lim;
		end else if (p < 0) begin
			r = '0;
		end else begin
			r = p;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/scf_if.sv -----
`default_nettype none
interface scf_in_if import scf_pkg::*; ();
	logic valid;
	logic ready;
	logic [ACT_W-1:0] action;
	coord_t coord_x;
	coord_t coord_y;
	logic [DT_W-1:0] delta_time;
	logic [RAD_W-1:0] radius;

	modport source (output valid, action, coord_x, coord_y, delta_time, radius,
		input ready);
	modport sink (input valid, action, coord_x, coord_y, delta_time, radius,
		output ready);
endinterface

interface scf_out_if import scf_pkg::*; ();
	logic valid;
	logic ready;
	coord_t pos_x;
	coord_t pos_y;
	logic visible;
	coord_t mapped_x;
	coord_t mapped_y;

	modport source (output valid, pos_x, pos_y, visible, mapped_x, mapped_y,
		input ready);
	modport sink (input valid, pos_x, pos_y, visible, mapped_x, mapped_y,
		output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/scf_mul.sv -----
`default_nettype none
module scf_mul import scf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [MUL_A_W-1:0] a,
	input logic [MUL_B_W-1:0] b,
	output logic busy,
	output logic [MUL_P_W-1:0] prod
);

	logic busy_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_P_W-1:0] mc_q;
	logic [MUL_B_W-1:0] mp_q;
	logic [MUL_P_W-1:0] acc_q;

	// one multiplier bit per cycle, shift and add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= MUL_CNT_W'(MUL_B_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= MUL_P_W'(a);
			mp_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ----- hw/rtl/scf_rootdiv.sv -----
`default_nettype none
module scf_rootdiv import scf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rd_ctl_t ctl,
	input logic [RD_W-1:0] num,
	input logic [ROOT_W-1:0] den,
	output logic busy,
	output logic [RD_W-1:0] result
);

	logic busy_q;
	logic root_q;
	logic [RD_CNT_W-1:0] cnt_q;
	logic [RD_W-1:0] acc_q;
	logic [RD_W-1:0] rt_q;
	logic [RD_W-1:0] bt_q;
	logic [DIV_R_W-1:0] rem_q;
	logic [ROOT_W-1:0] dv_q;

	logic [RD_W-1:0] trial;
	logic ge;
	logic [DIV_R_W-1:0] remx;
	logic rge;

	assign trial = rt_q + bt_q;
	assign ge = acc_q >= trial;
	assign remx = {rem_q[DIV_R_W-2:0], acc_q[RD_W-1]};
	assign rge = remx >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q <= ctl.root ? RD_CNT_W'(RD_W / 2 - 1) : RD_CNT_W'(RD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// root: two radicand bits per cycle; divide: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			root_q <= ctl.root;
			acc_q <= num;
			rt_q <= '0;
			bt_q <= RD_W'(1) << (RD_W - 2);
			rem_q <= '0;
			dv_q <= den;
		end else if (busy_q) begin
			if (root_q) begin
				if (ge) begin
					acc_q <= acc_q - trial;
					rt_q <= (rt_q >> 1) + bt_q;
				end else begin
					rt_q <= rt_q >> 1;
				end
				bt_q <= bt_q >> 2;
			end else begin
				acc_q <= acc_q << 1;
				rem_q <= rge ? remx - {1'b0, dv_q} : remx;
				rt_q <= {rt_q[RD_W-2:0], rge};
			end
		end
	end

	assign busy = busy_q;
	assign result = rt_q;

endmodule
`default_nettype wire

// ----- hw/rtl/scroll_camera_follow_clamp.sv -----
// channel  dir  modport          word
// cmd      in   scf_in_if.sink   action, coord_x, coord_y, delta_time, radius
// res      out  scf_out_if.source pos_x, pos_y, visible, mapped_x, mapped_y
// cfg      in   plain write      cfg_we, cfg_idx, cfg_data
//
// one word at a time; cmd.ready is high only between words
// set target, set position, snap, queries, mapping, follow in manual mode: no multiply
// manual move: two serial multiplies per axis
// follow tick: squares, root, step; partial step adds a multiply and a divide per axis
// a stalled result sits in the output register while the next word is taken
// reset loads the register defaults, zeroes the camera, centers the target
`default_nettype none
module scroll_camera_follow_clamp import scf_pkg::*; (
	input logic clk,
	input logic arst_n,
	scf_in_if.sink cmd,
	scf_out_if.source res,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [REG_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [REG_W-1:0] vw_q, vh_q, mw_q, mh_q, fs_q, ms_q;
	logic mode_q;

	coord_t cam_x_q, cam_y_q, tgt_x_q, tgt_y_q;
	act_t act_q;
	coord_t cx_q, cy_q;
	logic [DT_W-1:0] dt_q;
	logic [RAD_W-1:0] r_q;

	logic ax_q;
	coord_t des_x_q, des_y_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [RD_W-1:0] sum_q;
	logic [ROOT_W-1:0] dist_q;
	logic [STEP_W-1:0] step_q;
	logic vis_q;
	coord_t mx_q, my_q;

	logic out_vld_q;
	coord_t out_px_q, out_py_q, out_mx_q, out_my_q;
	logic out_vis_q;

	logic mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic mul_busy;
	logic [MUL_P_W-1:0] mul_prod;
	rd_ctl_t rd_ctl;
	logic rd_busy;
	logic [RD_W-1:0] rd_res;

	logic [REG_W+FRAC_BITS-2:0] half_w, half_h;
	coord_t des_x_c, des_y_c;
	logic signed [DIFF_W-1:0] d_sel;
	coord_t cam_sel, c_sel;
	logic [COORD_BITS-1:0] mag_d, mag_c;
	logic signed [SUM_W-1:0] step_mag;
	logic neg;
	coord_t upd;
	logic signed [CMP_W-1:0] cxe, cye, re, camxe, camye, wve, hve;
	logic vis_c;
	logic fin_load;

	scf_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.busy(mul_busy),
		.prod(mul_prod)
	);

	scf_rootdiv u_rootdiv (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(rd_ctl),
		.num((state_q == S_PD) ? RD_W'(mul_prod) : sum_q),
		.den(dist_q),
		.busy(rd_busy),
		.result(rd_res)
	);

	assign half_w = {vw_q, {(FRAC_BITS-1){1'b0}}};
	assign half_h = {vh_q, {(FRAC_BITS-1){1'b0}}};
	assign des_x_c = sat_c(SUM_W'(tgt_x_q) - SUM_W'(half_w));
	assign des_y_c = sat_c(SUM_W'(tgt_y_q) - SUM_W'(half_h));

	assign d_sel = ax_q ? dy_q : dx_q;
	assign cam_sel = ax_q ? cam_y_q : cam_x_q;
	assign c_sel = ax_q ? cy_q : cx_q;
	assign mag_d = d_sel[DIFF_W-1] ? COORD_BITS'(-d_sel) : COORD_BITS'(d_sel);
	assign mag_c = c_sel[COORD_BITS-1] ? COORD_BITS'(-c_sel) : COORD_BITS'(c_sel);

	assign step_mag = (state_q == S_PDW) ? $signed(SUM_W'(rd_res[STEP_W-1:0]))
		: $signed(SUM_W'(mul_prod[MUL_P_W-1:DT_W]));
	assign neg = (state_q == S_PDW) ? d_sel[DIFF_W-1] : c_sel[COORD_BITS-1];
	assign upd = sat_c(SUM_W'(cam_sel) + (neg ? -step_mag : step_mag));

	assign cxe = CMP_W'(cx_q);
	assign cye = CMP_W'(cy_q);
	assign re = $signed(CMP_W'(r_q));
	assign camxe = CMP_W'(cam_x_q);
	assign camye = CMP_W'(cam_y_q);
	assign wve = $signed(CMP_W'({vw_q, {FRAC_BITS{1'b0}}}));
	assign hve = $signed(CMP_W'({vh_q, {FRAC_BITS{1'b0}}}));
	assign vis_c = (cxe + re >= camxe) && (cxe - re <= camxe + wve)
		&& (cye + re >= camye) && (cye - re <= camye + hve);

	assign fin_load = (state_q == S_FIN) && (!out_vld_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		rd_ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (act_q)
					A_FOLLOW: state_d = mode_q ? S_CLAMP : S_DES;
					A_SNAP: state_d = S_DES;
					A_MANUAL: state_d = S_M1;
					A_SETPOS: state_d = S_CLAMP;
					default: state_d = S_FIN;
				endcase
			end
			S_DES: state_d = (act_q == A_SNAP) ? S_CLAMP : S_DIFF;
			S_DIFF: state_d = S_SQ;
			S_SQ: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(mag_d);
				mul_b = mag_d;
				state_d = S_SQW;
			end
			S_SQW: begin
				if (!mul_busy) begin
					state_d = ax_q ? S_ROOT : S_SQ;
				end
			end
			S_ROOT: begin
				rd_ctl.start = 1'b1;
				rd_ctl.root = 1'b1;
				state_d = S_ROOTW;
			end
			S_ROOTW: begin
				if (!rd_busy) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(fs_q);
				mul_b = MUL_B_W'(dt_q);
				state_d = S_STEPW;
			end
			S_STEPW: begin
				if (!mul_busy) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (dist_q <= ONE_PX || ROOT_W'(step_q) >= dist_q) begin
					state_d = S_CLAMP;
				end else begin
					state_d = S_PS;
				end
			end
			S_PS: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(mag_d);
				mul_b = MUL_B_W'(step_q);
				state_d = S_PSW;
			end
			S_PSW: begin
				if (!mul_busy) begin
					state_d = S_PD;
				end
			end
			S_PD: begin
				rd_ctl.start = 1'b1;
				state_d = S_PDW;
			end
			S_PDW: begin
				if (!rd_busy) begin
					state_d = ax_q ? S_CLAMP : S_PS;
				end
			end
			S_M1: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(ms_q);
				mul_b = mag_c;
				state_d = S_M1W;
			end
			S_M1W: begin
				if (!mul_busy) begin
					state_d = S_M2;
				end
			end
			S_M2: begin
				mul_start = 1'b1;
				mul_a = mul_prod[MUL_A_W-1:0];
				mul_b = MUL_B_W'(dt_q);
				state_d = S_M2W;
			end
			S_M2W: begin
				if (!mul_busy) begin
					state_d = ax_q ? S_CLAMP : S_M1;
				end
			end
			S_CLAMP: state_d = S_FIN;
			S_FIN: begin
				if (fin_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q <= VW_RST;
			vh_q <= VH_RST;
			mw_q <= VW_RST;
			mh_q <= VH_RST;
			fs_q <= FS_RST;
			ms_q <= MS_RST;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				R_VW: vw_q <= cfg_data;
				R_VH: vh_q <= cfg_data;
				R_MW: mw_q <= cfg_data;
				R_MH: mh_q <= cfg_data;
				R_FS: fs_q <= cfg_data;
				R_MS: ms_q <= cfg_data;
				R_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			tgt_x_q <= TGT_X_RST;
			tgt_y_q <= TGT_Y_RST;
			ax_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_DISP: begin
					ax_q <= 1'b0;
					if (act_q == A_TARGET) begin
						tgt_x_q <= cx_q;
						tgt_y_q <= cy_q;
					end
					if (act_q == A_SETPOS) begin
						cam_x_q <= cx_q;
						cam_y_q <= cy_q;
					end
				end
				S_DES: begin
					if (act_q == A_SNAP) begin
						cam_x_q <= des_x_c;
						cam_y_q <= des_y_c;
					end
				end
				S_SQW: begin
					if (!mul_busy) begin
						ax_q <= ~ax_q;
					end
				end
				S_DEC: begin
					ax_q <= 1'b0;
					if (dist_q <= ONE_PX || ROOT_W'(step_q) >= dist_q) begin
						cam_x_q <= des_x_q;
						cam_y_q <= des_y_q;
					end
				end
				S_PDW, S_M2W: begin
					if (!(state_q == S_PDW ? rd_busy : mul_busy)) begin
						ax_q <= ~ax_q;
						if (ax_q) begin
							cam_y_q <= upd;
						end else begin
							cam_x_q <= upd;
						end
					end
				end
				S_CLAMP: begin
					cam_x_q <= clamp_axis(cam_x_q, mw_q, vw_q);
					cam_y_q <= clamp_axis(cam_y_q, mh_q, vh_q);
				end
				default: ;
			endcase
			if (fin_load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			act_q <= act_t'(cmd.action);
			cx_q <= cmd.coord_x;
			cy_q <= cmd.coord_y;
			dt_q <= cmd.delta_time;
			r_q <= cmd.radius;
		end
		if (state_q == S_DISP) begin
			vis_q <= (act_q == A_VIS) ? vis_c : 1'b0;
			case (act_q)
				A_W2S: begin
					mx_q <= sat_c(SUM_W'(cx_q) - SUM_W'(cam_x_q));
					my_q <= sat_c(SUM_W'(cy_q) - SUM_W'(cam_y_q));
				end
				A_S2W: begin
					mx_q <= sat_c(SUM_W'(cx_q) + SUM_W'(cam_x_q));
					my_q <= sat_c(SUM_W'(cy_q) + SUM_W'(cam_y_q));
				end
				default: begin
					mx_q <= '0;
					my_q <= '0;
				end
			endcase
		end
		if (state_q == S_DES) begin
			des_x_q <= des_x_c;
			des_y_q <= des_y_c;
		end
		if (state_q == S_DIFF) begin
			dx_q <= DIFF_W'(des_x_q) - DIFF_W'(cam_x_q);
			dy_q <= DIFF_W'(des_y_q) - DIFF_W'(cam_y_q);
		end
		if (state_q == S_SQW && !mul_busy) begin
			sum_q <= ax_q ? sum_q + mul_prod[RD_W-1:0] : mul_prod[RD_W-1:0];
		end
		if (state_q == S_ROOTW && !rd_busy) begin
			dist_q <= rd_res[ROOT_W-1:0];
		end
		if (state_q == S_STEPW && !mul_busy) begin
			step_q <= mul_prod[STEP_W+(16-FRAC_BITS)-1:16-FRAC_BITS];
		end
		if (fin_load) begin
			out_px_q <= cam_x_q;
			out_py_q <= cam_y_q;
			out_vis_q <= vis_q;
			out_mx_q <= mx_q;
			out_my_q <= my_q;
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign res.valid = out_vld_q;
	assign res.pos_x = out_px_q;
	assign res.pos_y = out_py_q;
	assign res.visible = out_vis_q;
	assign res.mapped_x = out_mx_q;
	assign res.mapped_y = out_my_q;

endmodule
`default_nettype wire

// ----- hw/rtl/scf_check.sv -----
`default_nettype none
module scf_check import scf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input coord_t pos_x,
	input coord_t pos_y,
	input logic visible,
	input coord_t mapped_x,
	input coord_t mapped_y
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y)
			&& $stable(visible) && $stable(mapped_x) && $stable(mapped_y))
		else $error("stalled result word changed");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in work");

	a_vis_no_map: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> mapped_x == '0 && mapped_y == '0)
		else $error("visibility answer carries a mapped point");

endmodule

bind scroll_camera_follow_clamp scf_check u_scf_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(cmd.valid),
	.in_ready(cmd.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.pos_x(res.pos_x),
	.pos_y(res.pos_y),
	.visible(res.visible),
	.mapped_x(res.mapped_x),
	.mapped_y(res.mapped_y)
);
`default_nettype wire

// ----- tb/testbench.sv -----
module testbench import scf_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		coord_t px;
		coord_t py;
		logic vis;
		coord_t mx;
		coord_t my;
	} cam_word_t;

	typedef struct {
		act_t act;
		coord_t x;
		coord_t y;
		logic [DT_W-1:0] dt;
		logic [RAD_W-1:0] r;
		logic has_exp;
		cam_word_t exp_w;
	} stim_row_t;

	localparam longint CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [REG_W-1:0] cfg_data = '0;

	scf_in_if cmd ();
	scf_out_if res ();

	scroll_camera_follow_clamp dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.res(res.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// predictor state
	longint unsigned vw, vh, mw, mh, fspd, mspd;
	bit mmode;
	longint cam_x, cam_y, tgt_x, tgt_y;

	cam_word_t pending_words[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;

	initial cmd.valid = 1'b0;
	initial cmd.action = '0;
	initial cmd.coord_x = '0;
	initial cmd.coord_y = '0;
	initial cmd.delta_time = '0;
	initial cmd.radius = '0;
	initial res.ready = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint sat_coord(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint bound_axis(longint p, longint unsigned m, longint unsigned v);
		longint lim;
		if (m <= v) return sat_coord((longint'(m) - longint'(v)) * (64'sd1 <<< (FRAC_BITS - 1)));
		lim = longint'(m - v) <<< FRAC_BITS;
		if (p > lim) p = lim;
		if (p < 0) p = 0;
		return sat_coord(p);
	endfunction

	function automatic longint signed_part(longint d, longint unsigned st, longint unsigned dlen);
		longint unsigned q;
		q = mag(d) * st / dlen;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint manual_shift(longint d, longint unsigned dt);
		longint unsigned m;
		m = (mag(d) * mspd * dt) >> 16;
		return d < 0 ? -longint'(m) : longint'(m);
	endfunction

	task automatic follow_camera(longint unsigned dt);
		longint desx, desy, dx, dy;
		longint unsigned ax, ay, dlen, st;
		int s;
		desx = sat_coord(tgt_x - (longint'(vw) <<< (FRAC_BITS - 1)));
		desy = sat_coord(tgt_y - (longint'(vh) <<< (FRAC_BITS - 1)));
		dx = desx - cam_x;
		dy = desy - cam_y;
		ax = mag(dx);
		ay = mag(dy);
		s = 0;
		while ((ax >> s) >= (64'd1 << 31) || (ay >> s) >= (64'd1 << 31)) s++;
		dlen = root_floor((ax >> s) * (ax >> s) + (ay >> s) * (ay >> s)) << s;
		st = (fspd * dt) >> (16 - FRAC_BITS);
		if (dlen > (64'd1 << FRAC_BITS) && st < dlen) begin
			cam_x = sat_coord(cam_x + signed_part(dx, st, dlen));
			cam_y = sat_coord(cam_y + signed_part(dy, st, dlen));
		end else begin
			cam_x = desx;
			cam_y = desy;
		end
	endtask

	task automatic bound_camera();
		cam_x = bound_axis(cam_x, mw, vw);
		cam_y = bound_axis(cam_y, mh, vh);
	endtask

	task automatic predict_camera(input stim_row_t it, output cam_word_t w);
		longint cx, cy, r;
		cx = longint'(it.x);
		cy = longint'(it.y);
		r = longint'({1'b0, it.r});
		w.vis = 1'b0;
		w.mx = '0;
		w.my = '0;
		case (it.act)
			A_TARGET: begin
				tgt_x = cx;
				tgt_y = cy;
			end
			A_FOLLOW: begin
				if (!mmode) follow_camera(it.dt);
				bound_camera();
			end
			A_SNAP: begin
				cam_x = sat_coord(tgt_x - (longint'(vw) <<< (FRAC_BITS - 1)));
				cam_y = sat_coord(tgt_y - (longint'(vh) <<< (FRAC_BITS - 1)));
				bound_camera();
			end
			A_MANUAL: begin
				cam_x = sat_coord(cam_x + manual_shift(cx, it.dt));
				cam_y = sat_coord(cam_y + manual_shift(cy, it.dt));
				bound_camera();
			end
			A_SETPOS: begin
				cam_x = cx;
				cam_y = cy;
				bound_camera();
			end
			A_VIS: begin
				w.vis = (cx + r >= cam_x && cx - r <= cam_x + (longint'(vw) <<< FRAC_BITS) &&
					cy + r >= cam_y && cy - r <= cam_y + (longint'(vh) <<< FRAC_BITS));
			end
			A_W2S: begin
				w.mx = coord_t'(sat_coord(cx - cam_x));
				w.my = coord_t'(sat_coord(cy - cam_y));
			end
			default: begin
				w.mx = coord_t'(sat_coord(cx + cam_x));
				w.my = coord_t'(sat_coord(cy + cam_y));
			end
		endcase
		w.px = coord_t'(cam_x);
		w.py = coord_t'(cam_y);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// receiver and checker
	always @(posedge clk) begin
		cam_word_t e;
		if (res.valid && res.ready) begin
			if (pending_words.size() == 0) begin
				$display("unexpected word");
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (res.pos_x !== e.px) report_mismatch("pos_x", res.pos_x, e.px);
				if (res.pos_y !== e.py) report_mismatch("pos_y", res.pos_y, e.py);
				if (res.visible !== e.vis) report_mismatch("visible", res.visible, e.vis);
				if (res.mapped_x !== e.mx) report_mismatch("mapped_x", res.mapped_x, e.mx);
				if (res.mapped_y !== e.my) report_mismatch("mapped_y", res.mapped_y, e.my);
			end
		end
		res.ready <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			R_VW: vw = val;
			R_VH: vh = val;
			R_MW: mw = val;
			R_MH: mh = val;
			R_FS: fspd = val;
			R_MS: mspd = val;
			default: mmode = val[0];
		endcase
	endtask

	task automatic drain();
		while (pending_words.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// cmd valid stays high across back-to-back words
	task automatic send_word(input stim_row_t it);
		cam_word_t w;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= it.act;
		cmd.coord_x <= it.x;
		cmd.coord_y <= it.y;
		cmd.delta_time <= it.dt;
		cmd.radius <= it.r;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		predict_camera(it, w);
		if (it.has_exp && w != it.exp_w) begin
			$display("predictor disagrees with table row");
			errors++;
		end
		pending_words.push_back(w);
	endtask

	task automatic send_last();
		cmd.valid <= 1'b0;
	endtask

	function automatic coord_t rand_coord(int sel);
		case (sel)
			0: return coord_t'(CMAX);
			1: return coord_t'(CMIN);
			2: return coord_t'($urandom_range(0, 4000 * 256));
			3: return coord_t'(-$signed({1'b0, 24'($urandom_range(0, 2000 * 256))}));
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic stim_row_t rand_row();
		stim_row_t it;
		int p;
		p = $urandom_range(99);
		if (p < 20) it.act = A_FOLLOW;
		else if (p < 30) it.act = A_TARGET;
		else if (p < 40) it.act = A_MANUAL;
		else it.act = act_t'($urandom_range(7));
		it.x = rand_coord($urandom_range(0, 7));
		it.y = rand_coord($urandom_range(0, 7));
		it.dt = ($urandom_range(9) == 0) ? DT_W'($urandom) : DT_W'($urandom_range(0, 2000));
		it.r = ($urandom_range(3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 25600));
		it.has_exp = 0;
		return it;
	endfunction

	function automatic stim_row_t mk(act_t a, coord_t x, coord_t y, logic [DT_W-1:0] dt,
			logic [RAD_W-1:0] r);
		stim_row_t it;
		it.act = a;
		it.x = x;
		it.y = y;
		it.dt = dt;
		it.r = r;
		it.has_exp = 0;
		return it;
	endfunction

	function automatic stim_row_t mke(stim_row_t it, coord_t px, coord_t py, logic vis,
			coord_t mx, coord_t my);
		it.has_exp = 1;
		it.exp_w.px = px;
		it.exp_w.py = py;
		it.exp_w.vis = vis;
		it.exp_w.mx = mx;
		it.exp_w.my = my;
		return it;
	endfunction

	initial begin
		stim_row_t tbl[$];
		stim_row_t it;
		int ph;
		vw = 1280; vh = 720; mw = 1280; mh = 720;
		fspd = 2000; mspd = 500; mmode = 0;
		cam_x = 0; cam_y = 0;
		tgt_x = 640 * 256; tgt_y = 360 * 256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tbl.push_back(mke(mk(A_W2S, 25'sd0, 25'sd0, 0, 0), 0, 0, 0, 0, 0));
		tbl.push_back(mke(mk(A_FOLLOW, 0, 0, 16'hffff, 0), 0, 0, 0, 0, 0));
		tbl.push_back(mke(mk(A_S2W, coord_t'(CMAX), coord_t'(CMIN), 0, 0),
			0, 0, 0, coord_t'(CMAX), coord_t'(CMIN)));
		tbl.push_back(mke(mk(A_VIS, 0, 0, 0, 0), 0, 0, 1, 0, 0));
		tbl.push_back(mk(A_VIS, coord_t'(CMIN), coord_t'(CMAX), 0, 24'hffffff));
		tbl.push_back(mke(mk(A_SETPOS, coord_t'(CMAX), coord_t'(CMIN), 0, 0), 0, 0, 0, 0, 0));
		tbl.push_back(mk(A_TARGET, coord_t'(CMAX), coord_t'(CMAX), 0, 0));
		tbl.push_back(mk(A_SNAP, 0, 0, 0, 0));
		tbl.push_back(mk(A_MANUAL, coord_t'(CMAX), coord_t'(CMIN), 16'hffff, 0));
		tbl.push_back(mk(A_W2S, coord_t'(CMIN), coord_t'(CMAX), 0, 0));
		foreach (tbl[i]) send_word(tbl[i]);
		send_last();
		drain();

		// larger map so follow and clamp both move
		write_reg(R_MW, 16'd8000);
		write_reg(R_MH, 16'd6000);
		write_reg(R_VW, 16'd320);
		write_reg(R_VH, 16'd240);
		write_reg(R_FS, 16'hffff);
		write_reg(R_MS, 16'hffff);
		write_reg(R_MODE, 16'd0);
		tbl = {};
		tbl.push_back(mk(A_TARGET, 25'sd1000000, 25'sd700000, 0, 0));
		tbl.push_back(mk(A_FOLLOW, 0, 0, 0, 0));
		tbl.push_back(mk(A_FOLLOW, 0, 0, 16'd100, 0));
		tbl.push_back(mk(A_FOLLOW, 0, 0, 16'hffff, 0));
		tbl.push_back(mk(A_TARGET, coord_t'(CMIN), coord_t'(CMAX), 0, 0));
		tbl.push_back(mk(A_FOLLOW, 0, 0, 16'd500, 0));
		tbl.push_back(mk(A_MANUAL, 25'sd256, -25'sd256, 16'hffff, 0));
		tbl.push_back(mk(A_VIS, 25'sd5000, 25'sd5000, 0, 24'd100));
		foreach (tbl[i]) send_word(tbl[i]);
		send_last();
		drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 82; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 82; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			case (ph)
				0: ;
				1: begin write_reg(R_MODE, 16'd1); write_reg(R_FS, 16'd0); end
				2: begin
					write_reg(R_MODE, 16'd0);
					write_reg(R_VW, 16'hffff); write_reg(R_VH, 16'hffff);
					write_reg(R_MW, 16'd1); write_reg(R_MH, 16'd1);
				end
				3: begin
					write_reg(R_VW, 16'd1); write_reg(R_VH, 16'd1);
					write_reg(R_MW, 16'hffff); write_reg(R_MH, 16'hffff);
					write_reg(R_MS, 16'd0); write_reg(R_FS, 16'd30000);
				end
				default: begin
					write_reg(R_VW, REG_W'($urandom_range(1, 2000)));
					write_reg(R_VH, REG_W'($urandom_range(1, 2000)));
					write_reg(R_MW, REG_W'($urandom_range(1, 9000)));
					write_reg(R_MH, REG_W'($urandom_range(1, 9000)));
					write_reg(R_FS, REG_W'($urandom));
					write_reg(R_MS, REG_W'($urandom));
					write_reg(R_MODE, REG_W'($urandom_range(3) == 0));
				end
			endcase
			repeat (155) begin
				it = rand_row();
				send_word(it);
			end
			send_last();
			drain();
		end
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("testbench failed");
		$finish;
	end
endmodule
